// ===== src/cie_pkg.sv =====
// package for the instruction executor: payload types, codes, constants
// used by all modules under src except cie_ram
`timescale 1ns / 1ps
package cie_pkg;

  localparam int unsigned MemoryBytes = 65536;
  localparam int unsigned MaxBanks = 8;

  localparam logic [2:0] CmdTick = 3'd0;
  localparam logic [2:0] CmdLoad = 3'd1;
  localparam logic [2:0] CmdWinRd = 3'd2;
  localparam logic [2:0] CmdWinWr = 3'd3;
  localparam logic [2:0] CmdBoot = 3'd4;
  localparam logic [2:0] CmdHalt = 3'd5;

  localparam logic [1:0] CauseBudget = 2'd0;
  localparam logic [1:0] CauseWai = 2'd1;
  localparam logic [1:0] CauseHalt = 2'd2;
  localparam logic [1:0] CauseIdle = 2'd3;

  localparam logic [8:0] FlC = 9'h001;
  localparam logic [8:0] FlZ = 9'h002;
  localparam logic [8:0] FlX = 9'h010;
  localparam logic [8:0] FlM = 9'h020;
  localparam logic [8:0] FlN = 9'h080;
  localparam logic [8:0] FlE = 9'h100;

  localparam logic [15:0] ResetSp = 16'd512;
  localparam logic [15:0] ResetPc = 16'd1024;
  localparam logic [15:0] WarmPc = 16'd8192;

  localparam logic [0:0] CfgBanks = 1'd0;
  localparam logic [0:0] CfgCycles = 1'd1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] mem_address;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        is_running;
    logic [1:0]  stop_cause;
    logic [15:0] current_pc;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic        mem_req;   // start a byte access
    logic        mem_we;
    logic [15:0] mem_addr;
    logic [7:0]  mem_wdata;
    logic        host;      // host load, ignores bank limit
    logic        clr_init;  // clearing pass write
  } mem_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       rdy;
    logic [7:0] rdata;
  } mem_sts_t;

endpackage

// ===== src/cie_ram.sv =====
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module cie_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 65536
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/cie_datapath.sv =====
// memory datapath: bank check, ram, read return
// depends on cie_pkg, cie_ram
`timescale 1ns / 1ps
module cie_datapath #(
  parameter int unsigned MemBytes = cie_pkg::MemoryBytes,
  parameter int unsigned MaxBk = cie_pkg::MaxBanks
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [3:0]        banks_i,
  input  cie_pkg::mem_cmd_t cmd_i,
  output cie_pkg::mem_sts_t sts_o
);
  localparam int unsigned Aw = $clog2(MemBytes);

  logic [3:0] banks_eff;
  logic       in_bank, ok;
  logic       pend_q, oob_q;
  logic [7:0] ram_rd;
  logic       ram_we;

  assign banks_eff = (banks_i > 4'(MaxBk)) ? 4'(MaxBk) : banks_i;
  assign in_bank = (32'(cmd_i.mem_addr) < 32'(MemBytes)) &&
                   ({1'b0, cmd_i.mem_addr[15:13]} < banks_eff);
  assign ok = cmd_i.host ? (32'(cmd_i.mem_addr) < 32'(MemBytes)) : in_bank;
  assign ram_we = cmd_i.mem_req && cmd_i.mem_we && (ok || cmd_i.clr_init);

  cie_ram #(.Width(8), .Depth(MemBytes)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (cmd_i.mem_addr[Aw-1:0]),
    .wdata_i(cmd_i.mem_wdata),
    .rdata_o(ram_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      oob_q  <= 1'b0;
    end else begin
      pend_q <= cmd_i.mem_req;
      oob_q  <= !in_bank;
    end
  end

  assign sts_o.rdy = pend_q;
  assign sts_o.rdata = oob_q ? 8'hff : ram_rd;
endmodule

// ===== src/cie_ctrl.sv =====
// controller: command sequencer and instruction execution state machine
// depends on cie_pkg
`timescale 1ns / 1ps
module cie_ctrl #(
  parameter int unsigned MemBytes = cie_pkg::MemoryBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cie_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cie_pkg::out_item_t out_item_o,
  input  logic [9:0]         cpt_i,
  output cie_pkg::mem_cmd_t  mcmd_o,
  input  cie_pkg::mem_sts_t  msts_i
);
  localparam int unsigned Aw = $clog2(MemBytes);

  localparam logic [4:0] StClr = 5'd0;
  localparam logic [4:0] StIdle = 5'd1;
  localparam logic [4:0] StHost = 5'd2;
  localparam logic [4:0] StLoop = 5'd3;
  localparam logic [4:0] StOp = 5'd4;
  localparam logic [4:0] StRd = 5'd5;
  localparam logic [4:0] StWr = 5'd6;
  localparam logic [4:0] StDone = 5'd7;
  localparam logic [4:0] StCmp = 5'd8;
  localparam logic [4:0] StInc = 5'd9;

  // microcode sequence steps within an opcode
  logic [4:0]  st_q, st_d;
  logic [3:0]  step_q, step_d;
  logic [7:0]  op_q, op_d;
  logic [15:0] t_q, t_d;   // operand / address
  logic [15:0] v_q, v_d;   // data
  logic        wsec_q, wsec_d; // second byte pending
  logic [15:0] a_q, a_d, x_q, x_d, y_q, y_d, sp_q, sp_d, pc_q, pc_d, ip_q, ip_d;
  logic [7:0]  ah_q, ah_d;
  logic [8:0]  f_q, f_d;
  logic [16:0] bud_q, bud_d;
  logic        run_q, run_d, win_q, win_d, wai_q, wai_d;
  logic        busy_q, busy_d;
  logic [Aw:0] clr_q, clr_d;
  cie_pkg::in_item_t  it_q, it_d;
  cie_pkg::out_item_t res_q, res_d;
  logic        ov_q, ov_d;

  logic [16:0] cap, bsum;
  logic [8:0]  lf;
  logic        m8, x8;

  assign m8 = f_q[5];
  assign x8 = f_q[4];
  assign cap = 17'(cpt_i) * 17'd100;
  assign bsum = bud_q + 17'(cpt_i);

  assign in_ready_o = !busy_q && !ov_q && (st_q == StIdle);
  assign out_valid_o = ov_q;
  assign out_item_o = res_q;

  function automatic logic [15:0] nzmask(input logic narrow);
    nzmask = narrow ? 16'h0080 : 16'h8000;
  endfunction

  always_comb begin
    st_d = st_q; step_d = step_q; op_d = op_q; t_d = t_q; v_d = v_q; wsec_d = wsec_q;
    a_d = a_q; x_d = x_q; y_d = y_q; sp_d = sp_q; pc_d = pc_q; ip_d = ip_q; ah_d = ah_q;
    f_d = f_q; bud_d = bud_q; run_d = run_q; win_d = win_q; wai_d = wai_q;
    busy_d = busy_q; clr_d = clr_q; it_d = it_q; res_d = res_q; ov_d = ov_q;
    lf = f_q;
    mcmd_o = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (st_q)
      StClr: begin
        mcmd_o.mem_req = 1'b1;
        mcmd_o.mem_we = 1'b1;
        mcmd_o.clr_init = 1'b1;
        mcmd_o.mem_addr = 16'(clr_q[Aw-1:0]);
        mcmd_o.mem_wdata = (clr_q == '0) ? 8'd2 : ((clr_q == (Aw+1)'(1)) ? 8'd1 : 8'd0);
        clr_d = clr_q + 1'b1;
        if (clr_q == (Aw+1)'(MemBytes - 1)) begin
          st_d = StIdle;
        end
      end
      StIdle: begin
        if (in_valid_i && in_ready_o) begin
          it_d = in_item_i;
          busy_d = 1'b1;
          res_d.read_data = 8'd0;
          res_d.stop_cause = cie_pkg::CauseIdle;
          unique case (in_item_i.cmd)
            cie_pkg::CmdTick: begin
              if (!run_q) begin
                st_d = StDone;
              end else begin
                wai_d = 1'b0;
                bud_d = (bsum > cap) ? cap : bsum;
                st_d = StLoop;
              end
            end
            cie_pkg::CmdLoad: begin
              mcmd_o.mem_req = 1'b1;
              mcmd_o.mem_we = 1'b1;
              mcmd_o.host = 1'b1;
              mcmd_o.mem_addr = in_item_i.mem_address;
              mcmd_o.mem_wdata = in_item_i.write_byte;
              st_d = StDone;
            end
            cie_pkg::CmdWinRd: begin
              if (win_q) begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = {8'd0, in_item_i.mem_address[7:0]};
                st_d = StHost;
              end else begin
                st_d = StDone;
              end
            end
            cie_pkg::CmdWinWr: begin
              if (win_q) begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_we = 1'b1;
                mcmd_o.mem_addr = {8'd0, in_item_i.mem_address[7:0]};
                mcmd_o.mem_wdata = in_item_i.write_byte;
              end
              st_d = StDone;
            end
            cie_pkg::CmdBoot: begin
              if (run_q) begin
                sp_d = cie_pkg::ResetSp;
                pc_d = cie_pkg::WarmPc;
              end
              bud_d = '0;
              run_d = 1'b1;
              st_d = StDone;
            end
            cie_pkg::CmdHalt: begin
              run_d = 1'b0;
              st_d = StDone;
            end
            default: st_d = StDone;
          endcase
        end
      end
      StHost: begin
        if (msts_i.rdy) begin
          res_d.read_data = msts_i.rdata;
          st_d = StDone;
        end
      end
      StLoop: begin
        if (!run_q) begin
          res_d.stop_cause = cie_pkg::CauseHalt;
          st_d = StDone;
        end else if (bud_q == '0) begin
          res_d.stop_cause = wai_q ? cie_pkg::CauseWai : cie_pkg::CauseBudget;
          st_d = StDone;
        end else begin
          bud_d = bud_q - 1'b1;
          if (wai_q) begin
            res_d.stop_cause = cie_pkg::CauseWai;
            st_d = StDone;
          end else begin
            mcmd_o.mem_req = 1'b1;
            mcmd_o.mem_addr = pc_q;
            pc_d = pc_q + 1'b1;
            step_d = 4'd0;
            st_d = StOp;
          end
        end
      end
      StOp: begin
        // step 0 waits for opcode; later steps wait for fetched bytes
        if (msts_i.rdy) begin
          if (step_q == 4'd0) begin
            op_d = msts_i.rdata;
            step_d = 4'd1;
            st_d = StLoop;
            unique case (msts_i.rdata)
              8'h01, 8'h03, 8'h64, 8'h85, 8'h8d, 8'h92, 8'ha0, 8'ha2, 8'ha5, 8'ha9,
              8'had, 8'hc2, 8'hcd, 8'hd0, 8'he2, 8'he6, 8'hef, 8'hf0, 8'h4c: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = pc_q;
                pc_d = pc_q + 1'b1;
                st_d = StOp;
              end
              8'h02: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = ip_q;
                t_d = ip_q;
                ip_d = ip_q + 16'd2;
                wsec_d = 1'b1;
                step_d = 4'd1;
                st_d = StRd;
              end
              8'h42: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = ip_q;
                t_d = ip_q;
                ip_d = m8 ? ip_q + 16'd1 : ip_q + 16'd2;
                wsec_d = !m8;
                step_d = 4'd2;
                st_d = StRd;
              end
              8'h18: f_d = f_q & ~cie_pkg::FlC;
              8'h38: f_d = f_q | cie_pkg::FlC;
              8'h5c: begin
                ip_d = x_q;
                f_d[7] = (x_q & nzmask(x8)) != 0;
                f_d[1] = x_q == 16'd0;
              end
              8'h88: begin
                y_d = (y_q - 16'd1) & (x8 ? 16'h00ff : 16'hffff);
                f_d[7] = (y_d & nzmask(x8)) != 0;
                f_d[1] = y_d == 16'd0;
              end
              8'hcb: wai_d = 1'b1;
              8'hfb: begin
                if (f_q[8] != f_q[0]) begin
                  if (f_q[8]) begin
                    f_d[8] = 1'b0;
                    f_d[0] = 1'b1;
                  end else begin
                    f_d[8] = 1'b1;
                    f_d[0] = 1'b0;
                    if (!m8) ah_d = a_q[15:8];
                    f_d[5] = 1'b1;
                    f_d[4] = 1'b1;
                    a_d = a_q & 16'h00ff;
                    x_d = x_q & 16'h00ff;
                    y_d = y_q & 16'h00ff;
                  end
                end
              end
              default: run_d = 1'b0;
            endcase
          end else if (step_q == 4'd1) begin
            // first operand byte
            t_d = {8'd0, msts_i.rdata};
            st_d = StLoop;
            unique case (op_q)
              8'h4c, 8'h8d, 8'had, 8'hcd: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = pc_q;
                pc_d = pc_q + 1'b1;
                step_d = 4'd3;
                st_d = StOp;
              end
              8'ha9, 8'ha0, 8'ha2: begin
                v_d = {8'd0, msts_i.rdata};
                if ((op_q == 8'ha9) ? !m8 : !x8) begin
                  mcmd_o.mem_req = 1'b1;
                  mcmd_o.mem_addr = pc_q;
                  pc_d = pc_q + 1'b1;
                  step_d = 4'd4;
                  st_d = StOp;
                end else begin
                  step_d = 4'd5;
                  st_d = StCmp;
                end
              end
              8'h01: begin
                t_d = 16'(8'(msts_i.rdata + x_q[7:0]));
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = 16'(8'(msts_i.rdata + x_q[7:0]));
                wsec_d = 1'b1;
                step_d = 4'd6;
                st_d = StRd;
              end
              8'h92: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = {8'd0, msts_i.rdata};
                wsec_d = 1'b1;
                step_d = 4'd7;
                st_d = StRd;
              end
              8'h03: begin
                t_d = {8'd0, msts_i.rdata} + sp_q;
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = {8'd0, msts_i.rdata} + sp_q;
                wsec_d = !m8;
                step_d = 4'd8;
                st_d = StRd;
              end
              8'ha5, 8'he6: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = {8'd0, msts_i.rdata};
                wsec_d = !m8;
                step_d = (op_q == 8'ha5) ? 4'd9 : 4'd10;
                st_d = StRd;
              end
              8'h64, 8'h85: begin
                v_d = (op_q == 8'h64) ? 16'd0 : a_q;
                st_d = StWr;
              end
              8'hc2, 8'he2: begin
                lf = {f_q[8], (op_q == 8'hc2) ? (f_q[7:0] & ~msts_i.rdata)
                                             : (f_q[7:0] | msts_i.rdata)};
                f_d = lf;
                if (lf[8]) begin
                  f_d[5] = 1'b1;
                  f_d[4] = 1'b1;
                end else begin
                  if (lf[4]) begin
                    x_d = x_q & 16'h00ff;
                    y_d = y_q & 16'h00ff;
                  end
                  if (lf[5] != m8) begin
                    if (lf[5]) begin
                      ah_d = a_q[15:8];
                      a_d = a_q & 16'h00ff;
                    end else begin
                      a_d = {ah_q, a_q[7:0]};
                    end
                  end
                end
              end
              8'hd0, 8'hf0: begin
                if ((op_q == 8'hd0) ? !f_q[1] : f_q[1]) begin
                  pc_d = pc_q + {{8{msts_i.rdata[7]}}, msts_i.rdata};
                end
              end
              8'hef: begin
                unique case (msts_i.rdata)
                  8'h00, 8'h01, 8'h02, 8'h82: ;
                  8'h04: win_d = 1'b1;
                  8'h84: win_d = 1'b0;
                  default: run_d = 1'b0;
                endcase
              end
              default: ;
            endcase
          end else if (step_q == 4'd3) begin
            // high byte of absolute operand
            t_d = {msts_i.rdata, t_q[7:0]};
            st_d = StLoop;
            unique case (op_q)
              8'h4c: pc_d = {msts_i.rdata, t_q[7:0]};
              8'h8d: begin
                v_d = a_q;
                st_d = StWr;
              end
              default: begin
                mcmd_o.mem_req = 1'b1;
                mcmd_o.mem_addr = {msts_i.rdata, t_q[7:0]};
                wsec_d = !m8;
                step_d = (op_q == 8'had) ? 4'd9 : 4'd11;
                st_d = StRd;
              end
            endcase
          end else begin
            // step 4: immediate high byte
            v_d = {msts_i.rdata, v_q[7:0]};
            step_d = 4'd5;
            st_d = StCmp;
          end
        end
      end
      StRd: begin
        // read v at t, second byte at t+1 when wsec set
        if (msts_i.rdy) begin
          if (wsec_q) begin
            v_d = {8'd0, msts_i.rdata};
            wsec_d = 1'b0;
            mcmd_o.mem_req = 1'b1;
            mcmd_o.mem_addr = t_q + 16'd1;
            step_d = step_q | 4'h0;
            t_d = t_q;
            v_d[15] = 1'b1; // marker: second byte pending
            v_d[14:8] = 7'd0;
          end else begin
            st_d = StCmp;
            v_d = v_q[15] ? {msts_i.rdata, v_q[7:0]} : {8'd0, msts_i.rdata};
          end
        end
      end
      StCmp: begin
        // finish instruction using v
        st_d = StLoop;
        unique case (step_q)
          4'd1: pc_d = v_q;
          4'd2: a_d = v_q;
          4'd5: begin
            if (op_q == 8'ha9) begin
              a_d = v_q;
              f_d[7] = (v_q & nzmask(m8)) != 0;
            end else begin
              if (op_q == 8'ha0) y_d = v_q;
              else x_d = v_q;
              f_d[7] = (v_q & nzmask(x8)) != 0;
            end
            f_d[1] = v_q == 16'd0;
          end
          4'd6, 4'd7: begin
            t_d = v_q;
            if (step_q == 4'd7) begin
              v_d = a_q;
              st_d = StWr;
            end else begin
              mcmd_o.mem_req = 1'b1;
              mcmd_o.mem_addr = v_q;
              wsec_d = !m8;
              step_d = 4'd8;
              st_d = StRd;
            end
          end
          4'd8: begin
            a_d = a_q | v_q;
            f_d[7] = ((a_q | v_q) & nzmask(m8)) != 0;
            f_d[1] = (a_q | v_q) == 16'd0;
          end
          4'd9: begin
            a_d = v_q;
            f_d[7] = (v_q & nzmask(m8)) != 0;
            f_d[1] = v_q == 16'd0;
          end
          4'd10: begin
            v_d = (v_q + 16'd1) & (m8 ? 16'h00ff : 16'hffff);
            step_d = 4'd12;
            st_d = StInc;
          end
          4'd11: begin
            f_d[0] = a_q >= v_q;
            f_d[1] = a_q == v_q;
            f_d[7] = ((a_q - v_q) & nzmask(m8)) != 0;
          end
          default: ;
        endcase
      end
      StInc: begin
        f_d[7] = (v_q & nzmask(m8)) != 0;
        f_d[1] = v_q == 16'd0;
        st_d = StWr;
      end
      StWr: begin
        // low byte then high byte when m clear
        mcmd_o.mem_req = 1'b1;
        mcmd_o.mem_we = 1'b1;
        mcmd_o.mem_addr = t_q;
        mcmd_o.mem_wdata = v_q[7:0];
        if (!m8) begin
          t_d = t_q + 16'd1;
          v_d = {8'd0, v_q[15:8]};
          f_d = f_q | cie_pkg::FlM;
          ah_d = ah_q;
          st_d = StWr;
          wsec_d = 1'b1;
        end else begin
          st_d = StLoop;
        end
        if (wsec_q) begin
          f_d = f_q & ~cie_pkg::FlM;
          wsec_d = 1'b0;
          st_d = StLoop;
        end
      end
      StDone: begin
        if (!ov_q || out_ready_i) begin
          res_d.is_running = run_q;
          res_d.current_pc = pc_q;
          ov_d = 1'b1;
          busy_d = 1'b0;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr; step_q <= '0; op_q <= '0; t_q <= '0; v_q <= '0; wsec_q <= 1'b0;
      a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= cie_pkg::ResetSp; pc_q <= cie_pkg::ResetPc;
      ip_q <= '0; ah_q <= '0; f_q <= cie_pkg::FlE | cie_pkg::FlM | cie_pkg::FlX;
      bud_q <= '0; run_q <= 1'b0; win_q <= 1'b0; wai_q <= 1'b0; busy_q <= 1'b0;
      clr_q <= '0; it_q <= '0; res_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; step_q <= step_d; op_q <= op_d; t_q <= t_d; v_q <= v_d;
      wsec_q <= wsec_d; a_q <= a_d; x_q <= x_d; y_q <= y_d; sp_q <= sp_d; pc_q <= pc_d;
      ip_q <= ip_d; ah_q <= ah_d; f_q <= f_d; bud_q <= bud_d; run_q <= run_d;
      win_q <= win_d; wai_q <= wai_d; busy_q <= busy_d; clr_q <= clr_d; it_q <= it_d;
      res_q <= res_d; ov_q <= ov_d;
    end
  end
endmodule

// ===== src/cpu_instruction_executor.sv =====
// flow: host commands go from the idle state to the done state, a window read by way
// of the host state; a tick runs instructions through the single ram port until the
// budget is spent, a wai or a halt; one item at a time, none taken while a result is pending
// reset: async active low; a clearing pass over all MEMORY_BYTES ram bytes follows reset,
// no item is accepted during it
`timescale 1ns / 1ps
module cpu_instruction_executor #(
  parameter int unsigned MEMORY_BYTES = cie_pkg::MemoryBytes,
  parameter int unsigned MAX_BANKS = cie_pkg::MaxBanks
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cie_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output cie_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [9:0]         cfg_data_i
);
  logic [3:0] banks_q;
  logic [9:0] cpt_q;
  cie_pkg::mem_cmd_t mcmd;
  cie_pkg::mem_sts_t msts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      banks_q <= 4'd8;
      cpt_q <= 10'd1000;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cie_pkg::CfgBanks) banks_q <= cfg_data_i[3:0];
      else cpt_q <= cfg_data_i;
    end
  end

  cie_ctrl #(.MemBytes(MEMORY_BYTES)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_ready_o(in_ready_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o),
    .cpt_i(cpt_q), .mcmd_o(mcmd), .msts_i(msts)
  );

  cie_datapath #(.MemBytes(MEMORY_BYTES), .MaxBk(MAX_BANKS)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .banks_i(banks_q), .cmd_i(mcmd), .sts_o(msts)
  );
endmodule

// ===== src/cie_checker.sv =====
// port level checks for the instruction executor
// depends on cie_pkg; bound to cpu_instruction_executor
`timescale 1ns / 1ps
module cie_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input cie_pkg::out_item_t out_item_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("result dropped while stalled");
  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item taken while busy");
  a_no_take_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("item taken with result pending");
  a_idle_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.stop_cause != cie_pkg::CauseIdle |-> out_item_o.read_data == 8'd0)
    else $error("read data on tick result");
endmodule

bind cpu_instruction_executor cie_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
  .out_valid_o(out_valid_o), .out_ready_i(out_ready_i), .out_item_o(out_item_o)
);

// ===== sim/tb_top.sv =====
// testbench for cpu_instruction_executor: host commands and small random programs
// are checked item by item against an in-bench model of the core; needs cie_pkg
`timescale 1ns / 1ps
module tb_top;
  import cie_pkg::*;

  localparam int unsigned Limit = 4000000;
  localparam int unsigned Settle = 20;

  localparam logic [7:0] OpOraIndX = 8'h01, OpNxt = 8'h02, OpOraSr = 8'h03, OpClc = 8'h18;
  localparam logic [7:0] OpSec = 8'h38, OpEnt = 8'h42, OpJmp = 8'h4c, OpTxi = 8'h5c;
  localparam logic [7:0] OpStzDp = 8'h64, OpStaDp = 8'h85, OpDey = 8'h88, OpStaAbs = 8'h8d;
  localparam logic [7:0] OpStaInd = 8'h92, OpLdyImm = 8'ha0, OpLdxImm = 8'ha2, OpLdaDp = 8'ha5;
  localparam logic [7:0] OpLdaImm = 8'ha9, OpLdaAbs = 8'had, OpRep = 8'hc2, OpWai = 8'hcb;
  localparam logic [7:0] OpCmpAbs = 8'hcd, OpBne = 8'hd0, OpSep = 8'he2, OpIncDp = 8'he6;
  localparam logic [7:0] OpMmu = 8'hef, OpBeq = 8'hf0, OpXce = 8'hfb;
  localparam logic [7:0] OpBad = 8'hdb;
  localparam logic [7:0] MmuBus0 = 8'h00, MmuBus1 = 8'h01, MmuBus2 = 8'h02, MmuBus82 = 8'h82;
  localparam logic [7:0] MmuWinOn = 8'h04, MmuWinOff = 8'h84, MmuBad = 8'h55;
  localparam logic [2:0] CmdSpare6 = 3'd6, CmdSpare7 = 3'd7;

  localparam logic [7:0] OpList [27] = '{OpOraIndX, OpNxt, OpOraSr, OpClc, OpSec, OpEnt,
    OpJmp, OpTxi, OpStzDp, OpStaDp, OpDey, OpStaAbs, OpStaInd, OpLdyImm, OpLdxImm, OpLdaDp,
    OpLdaImm, OpLdaAbs, OpRep, OpWai, OpCmpAbs, OpBne, OpSep, OpIncDp, OpMmu, OpBeq, OpXce};
  localparam logic [7:0] MmuList [6] = '{MmuBus0, MmuBus1, MmuBus2, MmuBus82, MmuWinOn,
    MmuWinOff};

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_idx = CfgBanks;
  logic [9:0] cfg_data = '0;

  cpu_instruction_executor DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_item_o(out_item),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  in_item_t cmd_q[$];
  out_item_t want_q[$];
  int errors = 0;
  int pushed = 0;
  bit calm = 1'b0;
  int unsigned cycles = 0;

  // core model state
  logic [7:0] c_mem [0:65535];
  logic [15:0] c_a, c_ah, c_x, c_y, c_sp, c_pc, c_ip;
  logic [8:0] c_fl;
  int unsigned c_budget;
  bit c_run, c_win, c_wai;
  logic [3:0] c_banks;
  logic [9:0] c_cpt;

  function automatic bit fl(logic [8:0] f);
    return (c_fl & f) != 0;
  endfunction

  function automatic void setf(logic [8:0] f, bit on);
    c_fl = on ? (c_fl | f) : (c_fl & ~f);
  endfunction

  function automatic bit in_bank(logic [15:0] a);
    int unsigned b;
    b = (c_banks > MaxBanks) ? MaxBanks : c_banks;
    return (int'(a) >= MemoryBytes) ? 1'b0 : ((int'(a) >> 13) + 1 <= b);
  endfunction

  function automatic logic [7:0] rd(logic [15:0] a);
    return in_bank(a) ? c_mem[a] : 8'hff;
  endfunction

  function automatic void wr(logic [15:0] a, logic [7:0] v);
    if (in_bank(a)) c_mem[a] = v;
  endfunction

  function automatic logic [7:0] fetch();
    logic [7:0] v;
    v = rd(c_pc);
    c_pc = c_pc + 16'd1;
    return v;
  endfunction

  function automatic logic [15:0] rd_w(logic [15:0] a);
    logic [15:0] a1;
    a1 = a + 16'd1;
    return {rd(a1), rd(a)};
  endfunction

  function automatic logic [15:0] fetch_w();
    logic [7:0] lo, hi;
    lo = fetch();
    hi = fetch();
    return {hi, lo};
  endfunction

  function automatic logic [15:0] fetch_wide(bit narrow);
    logic [15:0] v;
    v = {8'h00, fetch()};
    if (!narrow) v[15:8] = fetch();
    return v;
  endfunction

  function automatic logic [15:0] rd_m(logic [15:0] a);
    logic [15:0] v, a1;
    a1 = a + 16'd1;
    v = {8'h00, rd(a)};
    if (!fl(FlM)) v[15:8] = rd(a1);
    return v;
  endfunction

  function automatic void wr_m(logic [15:0] a, logic [15:0] v);
    logic [15:0] a1;
    a1 = a + 16'd1;
    wr(a, v[7:0]);
    if (!fl(FlM)) wr(a1, v[15:8]);
  endfunction

  function automatic void set_nz(logic [15:0] v, bit narrow);
    setf(FlN, narrow ? v[7] : v[15]);
    setf(FlZ, v == 16'd0);
  endfunction

  function automatic void load_low(logic [7:0] low);
    bit old_m;
    old_m = fl(FlM);
    c_fl = {c_fl[8], low};
    if (fl(FlE)) begin
      setf(FlM | FlX, 1'b1);
      return;
    end
    if (fl(FlX)) begin
      c_x = c_x & 16'h00ff;
      c_y = c_y & 16'h00ff;
    end
    if (fl(FlM) != old_m) begin
      if (fl(FlM)) begin
        c_ah = c_a >> 8;
        c_a = c_a & 16'h00ff;
      end else begin
        c_a = c_a | {c_ah[7:0], 8'h00};
      end
    end
  endfunction

  function automatic void branch(bit taken);
    logic [7:0] b;
    b = fetch();
    if (taken) c_pc = c_pc + {{8{b[7]}}, b};
  endfunction

  function automatic void exec_one();
    logic [7:0] op, b;
    logic [15:0] a, v, d;
    op = fetch();
    case (op)
      OpOraIndX: begin
        b = fetch() + c_x[7:0];
        c_a = c_a | rd_m(rd_w({8'h00, b}));
        set_nz(c_a, fl(FlM));
      end
      OpNxt: begin
        c_pc = rd_w(c_ip);
        c_ip = c_ip + 16'd2;
      end
      OpOraSr: begin
        a = {8'h00, fetch()} + c_sp;
        c_a = c_a | rd_m(a);
        set_nz(c_a, fl(FlM));
      end
      OpClc: setf(FlC, 1'b0);
      OpSec: setf(FlC, 1'b1);
      OpEnt: begin
        if (fl(FlM)) begin
          c_a = {8'h00, rd(c_ip)};
          c_ip = c_ip + 16'd1;
        end else begin
          c_a = rd_w(c_ip);
          c_ip = c_ip + 16'd2;
        end
      end
      OpJmp: c_pc = fetch_w();
      OpTxi: begin
        c_ip = c_x;
        set_nz(c_x, fl(FlX));
      end
      OpStzDp: wr_m({8'h00, fetch()}, 16'd0);
      OpStaDp: wr_m({8'h00, fetch()}, c_a);
      OpDey: begin
        c_y = (c_y - 16'd1) & (fl(FlX) ? 16'h00ff : 16'hffff);
        set_nz(c_y, fl(FlX));
      end
      OpStaAbs: wr_m(fetch_w(), c_a);
      OpStaInd: wr_m(rd_w({8'h00, fetch()}), c_a);
      OpLdyImm: begin
        c_y = fetch_wide(fl(FlX));
        set_nz(c_y, fl(FlX));
      end
      OpLdxImm: begin
        c_x = fetch_wide(fl(FlX));
        set_nz(c_x, fl(FlX));
      end
      OpLdaDp: begin
        c_a = rd_m({8'h00, fetch()});
        set_nz(c_a, fl(FlM));
      end
      OpLdaImm: begin
        c_a = fetch_wide(fl(FlM));
        set_nz(c_a, fl(FlM));
      end
      OpLdaAbs: begin
        c_a = rd_m(fetch_w());
        set_nz(c_a, fl(FlM));
      end
      OpRep: begin
        b = fetch();
        load_low(c_fl[7:0] & ~b);
      end
      OpWai: c_wai = 1'b1;
      OpCmpAbs: begin
        v = rd_m(fetch_w());
        d = c_a - v;
        setf(FlC, c_a >= v);
        setf(FlZ, c_a == v);
        setf(FlN, fl(FlM) ? d[7] : d[15]);
      end
      OpBne: branch(!fl(FlZ));
      OpSep: begin
        b = fetch();
        load_low(c_fl[7:0] | b);
      end
      OpIncDp: begin
        a = {8'h00, fetch()};
        v = (rd_m(a) + 16'd1) & (fl(FlM) ? 16'h00ff : 16'hffff);
        wr_m(a, v);
        set_nz(v, fl(FlM));
      end
      OpMmu: begin
        b = fetch();
        case (b)
          MmuBus0, MmuBus1, MmuBus2, MmuBus82: ;
          MmuWinOn: c_win = 1'b1;
          MmuWinOff: c_win = 1'b0;
          default: c_run = 1'b0;
        endcase
      end
      OpBeq: branch(fl(FlZ));
      OpXce: begin
        if (fl(FlE) != fl(FlC)) begin
          if (fl(FlE)) begin
            setf(FlE, 1'b0);
            setf(FlC, 1'b1);
          end else begin
            setf(FlE, 1'b1);
            setf(FlC, 1'b0);
            if (!fl(FlM)) c_ah = c_a >> 8;
            setf(FlM | FlX, 1'b1);
            c_a = c_a & 16'h00ff;
            c_x = c_x & 16'h00ff;
            c_y = c_y & 16'h00ff;
          end
        end
      end
      default: c_run = 1'b0;
    endcase
  endfunction

  function automatic logic [1:0] run_tick();
    int unsigned cap;
    cap = 100 * c_cpt;
    if (!c_run) return CauseIdle;
    c_wai = 1'b0;
    c_budget = c_budget + c_cpt;
    if (c_budget > cap) c_budget = cap;
    while (1) begin
      if (!c_run) return CauseHalt;
      if (c_budget == 0) return c_wai ? CauseWai : CauseBudget;
      c_budget = c_budget - 1;
      if (c_wai) return CauseWai;
      exec_one();
    end
  endfunction

  function automatic out_item_t predict_item(in_item_t it);
    out_item_t r;
    r = '0;
    r.stop_cause = CauseIdle;
    case (it.cmd)
      CmdTick: r.stop_cause = run_tick();
      CmdLoad: c_mem[it.mem_address] = it.write_byte;
      CmdWinRd: if (c_win) r.read_data = rd({8'h00, it.mem_address[7:0]});
      CmdWinWr: if (c_win) wr({8'h00, it.mem_address[7:0]}, it.write_byte);
      CmdBoot: begin
        if (c_run) begin
          c_sp = ResetSp;
          c_pc = WarmPc;
        end
        c_budget = 0;
        c_run = 1'b1;
      end
      CmdHalt: c_run = 1'b0;
      default: ;
    endcase
    r.is_running = c_run;
    r.current_pc = c_pc;
    return r;
  endfunction

  task automatic report(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0h, expected %0h", what, got, want);
    errors++;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (in_valid && in_ready) want_q.push_back(predict_item(in_item));
    if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0 && (calm || $urandom_range(0, 3) != 0)) begin
        in_item <= cmd_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        if (!calm && cmd_q.size() > 0) in_gap = $urandom_range(0, 6);
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  int out_gap = 0;
  out_item_t want;
  always @(posedge clk_i) begin
    if (out_valid && out_ready) begin
      if (want_q.size() == 0) begin
        report("unexpected item", out_item.current_pc, '0);
      end else begin
        want = want_q.pop_front();
        if (out_item.read_data != want.read_data)
          report("read_data", out_item.read_data, want.read_data);
        if (out_item.is_running != want.is_running)
          report("is_running", out_item.is_running, want.is_running);
        if (out_item.stop_cause != want.stop_cause)
          report("stop_cause", out_item.stop_cause, want.stop_cause);
        if (out_item.current_pc != want.current_pc)
          report("current_pc", out_item.current_pc, want.current_pc);
      end
    end
    if (out_gap > 0) begin
      out_gap--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_gap = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > Limit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic push(logic [2:0] cmd, logic [15:0] addr, logic [7:0] b);
    in_item_t it;
    it.cmd = cmd;
    it.mem_address = addr;
    it.write_byte = b;
    cmd_q.push_back(it);
    pushed++;
  endtask

  task automatic drain();
    @(negedge clk_i);
    while (cmd_q.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_cfg(logic [0:0] idx, logic [9:0] val);
    drain();
    repeat (Settle) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgBanks) c_banks = val[3:0];
    else c_cpt = val;
  endtask

  // loads a program where the next boot will start it, then boots and ticks
  task automatic run_program(logic [7:0] prog[$], int ticks, bit reboot);
    logic [15:0] base;
    drain();
    base = c_run ? WarmPc : c_pc;
    foreach (prog[i]) push(CmdLoad, base + 16'(i), prog[i]);
    push(CmdBoot, 16'($urandom), 8'($urandom));
    repeat (ticks) push(CmdTick, 16'($urandom), 8'($urandom));
    if (reboot) begin
      push(CmdBoot, 16'($urandom), 8'($urandom));
      push(CmdTick, 16'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_program(int n_ins, int ticks);
    logic [7:0] prog[$];
    logic [7:0] op;
    logic [15:0] base, here;
    base = c_run ? WarmPc : c_pc;
    prog = {};
    if ($urandom_range(0, 2) == 0) prog = {OpClc, OpXce, OpRep, 8'h30};
    repeat (n_ins) begin
      op = ($urandom_range(0, 9) == 0) ? 8'($urandom) : OpList[$urandom_range(0, 26)];
      prog.push_back(op);
      if (op == OpMmu) begin
        prog.push_back($urandom_range(0, 4) == 0 ? 8'($urandom) : MmuList[$urandom_range(0, 5)]);
      end else if (!(op inside {OpNxt, OpClc, OpSec, OpEnt, OpTxi, OpDey, OpWai, OpXce})) begin
        prog.push_back(8'($urandom));
        prog.push_back(8'($urandom));
      end
    end
    case ($urandom_range(0, 3))
      0: prog.push_back(OpWai);
      1: begin
        here = base + 16'(prog.size());
        prog.push_back(OpJmp);
        prog.push_back(here[7:0]);
        prog.push_back(here[15:8]);
      end
      2: ;
      default: begin
        prog.push_back(OpMmu);
        prog.push_back(8'($urandom));
      end
    endcase
    run_program(prog, ticks, $urandom_range(0, 4) == 0);
  endtask

  task automatic noise(int n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0)
        push(3'($urandom_range(CmdWinRd, CmdWinWr)), 16'($urandom), 8'($urandom));
      else
        push(3'($urandom_range(0, 7)), 16'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    logic [7:0] prog[$];
    logic [15:0] here;
    int rand_items;
    for (int i = 0; i < 65536; i++) c_mem[i] = 8'h00;
    c_mem[0] = 8'h02;
    c_mem[1] = 8'h01;
    c_a = '0; c_ah = '0; c_x = '0; c_y = '0; c_ip = '0;
    c_sp = ResetSp;
    c_pc = ResetPc;
    c_fl = FlE | FlM | FlX;
    c_budget = 0;
    c_run = 1'b0; c_win = 1'b0; c_wai = 1'b0;
    c_banks = 4'd8;
    c_cpt = 10'd1000;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: idle commands, window while off, load extremes
    set_cfg(CfgCycles, 10'd50);
    push(CmdSpare6, 16'hffff, 8'hff);
    push(CmdSpare7, 16'h0000, 8'h00);
    push(CmdHalt, 16'h1234, 8'h56);
    push(CmdTick, 16'h0000, 8'h00);
    push(CmdWinRd, 16'h0000, 8'h00);
    push(CmdWinWr, 16'h00ff, 8'hff);
    push(CmdLoad, 16'hffff, 8'hff);
    push(CmdLoad, 16'h8000, 8'h00);

    // window on, store, wait, then warm boot while running
    prog = {OpMmu, MmuWinOn, OpLdaImm, 8'h7f, OpStaDp, 8'h10, OpWai};
    run_program(prog, 1, 1'b0);
    push(CmdWinRd, 16'hff10, 8'h00);
    push(CmdWinWr, 16'h0010, 8'h80);
    push(CmdWinRd, 16'h0010, 8'h00);
    push(CmdBoot, 16'h0000, 8'h00);
    push(CmdTick, 16'h0000, 8'h00);

    // native mode walk through most opcodes, then an unknown opcode
    prog = {OpClc, OpXce, OpRep, 8'h30, OpLdaImm, 8'hff, 8'hff, OpStaDp, 8'h20, OpIncDp, 8'h20,
      OpLdxImm, 8'h80, 8'h00, OpTxi, OpEnt, OpLdyImm, 8'h00, 8'h00, OpDey, OpCmpAbs, 8'h20,
      8'h00, OpBeq, 8'h00, OpBne, 8'h00, OpOraIndX, 8'h10, OpOraSr, 8'h01, OpStaInd, 8'h20,
      OpStzDp, 8'h22, OpSep, 8'h30, OpRep, 8'h30, OpSec, OpXce, OpMmu, MmuBus82,
      OpMmu, MmuWinOff, OpLdaAbs, 8'h20, 8'h00, OpStaAbs, 8'h40, 8'h00, OpBad};
    run_program(prog, 2, 1'b0);
    prog = {OpNxt};
    run_program(prog, 1, 1'b0);
    prog = {OpMmu, MmuBad};
    run_program(prog, 1, 1'b0);

    // budget spent by a tight loop at a high and a low rate
    set_cfg(CfgCycles, 10'd1000);
    drain();
    here = c_run ? WarmPc : c_pc;
    prog = {OpJmp, here[7:0], here[15:8]};
    run_program(prog, 2, 1'b0);
    set_cfg(CfgCycles, 10'd1);
    push(CmdTick, 16'h0000, 8'h00);
    push(CmdHalt, 16'h0000, 8'h00);
    set_cfg(CfgBanks, 4'd1);
    random_program(3, 2);
    push(CmdWinRd, 16'h00ff, 8'h00);

    // random part
    rand_items = pushed;
    while (pushed - rand_items < 150) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          drain();
          random_program($urandom_range(2, 12), $urandom_range(1, 4));
        end
        6, 7, 8: noise($urandom_range(1, 4));
        default: begin
          if ($urandom_range(0, 1) == 0) set_cfg(CfgBanks, 10'($urandom_range(1, 8)));
          else set_cfg(CfgCycles, 10'($urandom_range(1, 20)));
        end
      endcase
    end

    calm = 1'b1;
    set_cfg(CfgBanks, 10'd8);
    drain();
    random_program(8, 3);
    noise(6);

    drain();
    repeat (Settle) @(posedge clk_i);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
